[design/f2h_pkg.sv]
package f2h_pkg;
  localparam int unsigned SINGLE_W = 32;
  localparam int unsigned HALF_W   = 16;
  localparam logic [15:0] INF16    = 16'h7c00;
  localparam logic [15:0] QNAN16   = 16'h7e00;

  // Classification carried from decode to pack.
  typedef enum logic [2:0] {
    CLS_ZERO,
    CLS_SUB,
    CLS_NORM,
    CLS_INF,
    CLS_NAN
  } cls_t;

  typedef struct packed {
    logic        sign;
    cls_t        cls;
    logic [4:0]  exp;    // rebiased exponent for normals
    logic [3:0]  shift;  // 1..11 for subnormals
    logic [23:0] mant;   // hidden one and fraction
  } dec_t;
endpackage

[design/float32_to_float16_convert.sv]
// Binary32 to binary16 converter. One item (a 32-bit word) is taken in every
// clock cycle: busy is tied low, so an item is accepted whenever start is high.
// Each result appears on out_half_bits, registered by decode, align and pack, with
// out_valid high for one cycle; the receiver cannot stall, so take it then.
// The three register stages are decode, subnormal align and round/pack.
// Rounding is to nearest with ties away from zero; NaN keeps its sign: 0x7e00 or 0xfe00.
module float32_to_float16_convert (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_single_bits,
  output logic        out_valid,
  output logic [15:0] out_half_bits
);
  import f2h_pkg::*;

  logic v1, v2;
  dec_t d1, d2;

  // Pipeline never holds off: every stage advances each cycle.
  assign busy = 1'b0;

  f2h_decode u_dec (
    .clk(clk), .rst_n(rst_n), .vld_in(start), .word_in(in_single_bits),
    .vld_out(v1), .dec_out(d1)
  );

  f2h_align u_aln (
    .clk(clk), .rst_n(rst_n), .vld_in(v1), .dec_in(d1),
    .vld_out(v2), .dec_out(d2)
  );

  f2h_pack u_pck (
    .clk(clk), .rst_n(rst_n), .vld_in(v2), .dec_in(d2),
    .vld_out(out_valid), .half_out(out_half_bits)
  );

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##3 out_valid)
    else $error("result missing three cycles after item");
  a_nolie: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 3))
    else $error("result without item");
  a_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");
endmodule

[design/f2h_decode.sv]
module f2h_decode (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 vld_in,
  input  logic [31:0]          word_in,
  output logic                 vld_out,
  output f2h_pkg::dec_t        dec_out
);
  import f2h_pkg::*;

  logic       vld_r;
  dec_t       dec_r, dec_nxt;
  logic [7:0] bexp;
  logic signed [9:0] e;

  always_comb begin
    bexp = word_in[30:23];
    e = $signed({2'b00, bexp}) - 10'sd112;
    dec_nxt.sign  = word_in[31];
    dec_nxt.exp   = e[4:0];
    dec_nxt.shift = 4'(10'sd1 - e);
    dec_nxt.mant  = {1'b1, word_in[22:0]};
    if (bexp == 8'hff) begin
      dec_nxt.cls = (word_in[22:0] == 23'd0) ? CLS_INF : CLS_NAN;
    end else if (e < -10'sd10) begin
      dec_nxt.cls = CLS_ZERO;
    end else if (e <= 10'sd0) begin
      dec_nxt.cls = CLS_SUB;
    end else if (e > 10'sd30) begin
      dec_nxt.cls = CLS_INF;
    end else begin
      dec_nxt.cls = CLS_NORM;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
    dec_r <= dec_nxt;
  end

  assign vld_out = vld_r;
  assign dec_out = dec_r;
endmodule

[design/f2h_align.sv]
module f2h_align (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          vld_in,
  input  f2h_pkg::dec_t dec_in,
  output logic          vld_out,
  output f2h_pkg::dec_t dec_out
);
  import f2h_pkg::*;

  logic vld_r;
  dec_t dec_r, dec_nxt;

  // Shift subnormals into place so the pack stage rounds a fixed field.
  always_comb begin
    dec_nxt = dec_in;
    if (dec_in.cls == CLS_SUB) begin
      dec_nxt.mant = dec_in.mant >> dec_in.shift;
      dec_nxt.exp  = 5'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
    dec_r <= dec_nxt;
  end

  assign vld_out = vld_r;
  assign dec_out = dec_r;
endmodule

[design/f2h_pack.sv]
module f2h_pack (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          vld_in,
  input  f2h_pkg::dec_t dec_in,
  output logic          vld_out,
  output logic [15:0]   half_out
);
  import f2h_pkg::*;

  logic        vld_r;
  logic [15:0] half_r, half_nxt;
  logic [10:0] rnd;
  logic [5:0]  e1;

  always_comb begin
    // round half away: add at bit 12 of the 23-bit fraction field
    rnd = {1'b0, dec_in.mant[22:13]} + {10'd0, dec_in.mant[12]};
    e1  = {1'b0, dec_in.exp} + 6'd1;
    case (dec_in.cls)
      CLS_ZERO: half_nxt = {dec_in.sign, 15'd0};
      CLS_INF:  half_nxt = {dec_in.sign, 15'd0} | INF16;
      CLS_NAN:  half_nxt = {dec_in.sign, 15'd0} | QNAN16;
      CLS_SUB:  begin
        // a carry out lands on the smallest normal exponent
        half_nxt = {dec_in.sign, 4'd0, rnd[10:0]};
      end
      CLS_NORM: begin
        if (rnd[10]) begin
          if (e1 > 6'd30) begin
            half_nxt = {dec_in.sign, 15'd0} | INF16;
          end else begin
            half_nxt = {dec_in.sign, e1[4:0], 10'd0};
          end
        end else begin
          half_nxt = {dec_in.sign, dec_in.exp, rnd[9:0]};
        end
      end
      default: half_nxt = {dec_in.sign, 15'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
    half_r <= half_nxt;
  end

  assign vld_out  = vld_r;
  assign half_out = half_r;

  a_nan_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    vld_in && dec_in.cls == CLS_NAN |=> half_r[14:0] == QNAN16[14:0])
    else $error("NaN did not become quiet NaN");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    vld_in && dec_in.cls == CLS_ZERO |=> half_r[14:0] == 15'd0)
    else $error("underflow not zero");
  a_sign: assert property (@(posedge clk) disable iff (!rst_n)
    vld_in |=> half_r[15] == $past(dec_in.sign))
    else $error("sign lost");
endmodule

[sim/f2h_checker.sv]
module f2h_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [31:0] in_single_bits,
  input  logic        out_valid,
  input  logic [15:0] out_half_bits,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0] half_q[$];

  function automatic logic [15:0] single_to_half(input logic [31:0] w);
    logic [15:0] sgn;
    logic [7:0]  bexp;
    int          e;
    logic [23:0] frac;
    sgn  = {w[31], 15'b0};
    bexp = w[30:23];
    e    = int'(bexp) - 127 + 15;
    frac = {1'b0, w[22:0]};
    if (e <= 0) begin
      if (e < -10) return sgn;
      frac = (frac | 24'h800000) >> (1 - e);
      if (frac[12]) frac = frac + 24'h2000;
      return sgn | 16'(frac >> 13);
    end
    if (bexp == 8'hff) return sgn | ((frac == 0) ? f2h_pkg::INF16 : f2h_pkg::QNAN16);
    if (e > 30) return sgn | f2h_pkg::INF16;
    if (frac[12]) begin
      frac = frac + 24'h2000;
      if (frac[23]) begin
        if (e + 1 > 30) return sgn | f2h_pkg::INF16;
        return sgn | 16'((e + 1) << 10);
      end
    end
    return sgn | 16'(e << 10) | 16'(frac >> 13);
  endfunction

  assign pending = half_q.size();

  always @(posedge clk) begin
    logic [15:0] want;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (start && !busy) half_q.push_back(single_to_half(in_single_bits));
      if (out_valid) begin
        if (half_q.size() == 0) begin
          $error("result with nothing expected: half_bits %h", out_half_bits);
          fail_count <= fail_count + 1;
        end else begin
          want = half_q.pop_front();
          if (want !== out_half_bits) begin
            $error("half_bits mismatch: expected %h actual %h", want, out_half_bits);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

[sim/float32_to_float16_convert_tb.sv]
module float32_to_float16_convert_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_single_bits = '0;
  logic        out_valid;
  logic [15:0] out_half_bits;
  int          fail_count;
  int          pending;
  int          idle_pct;
  int          quiet_cycles;

  always #5 clk = ~clk;

  float32_to_float16_convert i_dut (.*);

  f2h_checker i_checker (.*);

  // Count cycles with no traffic; a stuck block ends the run.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Build a word biased toward interesting exponents: the rounding edges,
  // the half subnormal band, overflow, the all-zeros and the all-ones exponent.
  function automatic logic [31:0] pick_single();
    logic [31:0] w;
    logic [7:0]  ex;
    w = $urandom;
    case ($urandom_range(0, 5))
      0: ex = 8'($urandom_range(102, 112));   // subnormal band
      1: ex = 8'($urandom_range(113, 142));   // normal half range
      2: ex = 8'($urandom_range(142, 144));   // overflow edge
      3: ex = ($urandom_range(0, 1)) ? 8'hff : 8'h00;
      default: ex = w[30:23];
    endcase
    w[30:23] = ex;
    // Sometimes force a tie or near-tie in the rounding bits.
    if ($urandom_range(0, 3) == 0) w[12:0] = {1'b1, 12'($urandom_range(0, 1))};
    return w;
  endfunction

  // Present one item, holding it (with idle gaps) until accepted.
  task automatic send_item(input logic [31:0] w);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start          <= 1'b1;
    in_single_bits <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [31:0] directed[$];
    directed = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807f_ffff,
                 32'h7f80_0000, 32'hff80_0000, 32'h7fc0_0001, 32'hff80_0001,
                 32'h7fff_ffff, 32'h3f80_0000, 32'hbf80_1000, 32'h3f80_0fff,
                 32'h477f_e000, 32'h477f_f000, 32'h4780_0000, 32'h7f7f_ffff,
                 32'h3880_0000, 32'h387f_f000, 32'h3380_0000, 32'h3300_0000,
                 32'h3400_0000, 32'hb3ff_ffff, 32'h3f80_3000, 32'hffff_ffff};
    idle_pct = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) send_item(directed[i]);

    // Random phases: no idling, heavy sender idling, a receiver-stall phase
    // (the receiver cannot stall, so no gaps), then light sender idling.
    for (int p = 0; p < 4; p++) begin
      idle_pct = (p == 1) ? 72 : (p == 3) ? 17 : 0;
      repeat (357) send_item(pick_single());
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

[files.f]
design/f2h_pkg.sv
design/f2h_decode.sv
design/f2h_align.sv
design/f2h_pack.sv
design/float32_to_float16_convert.sv
sim/f2h_checker.sv
sim/float32_to_float16_convert_tb.sv
